[src/lcdns_pkg.sv]
// Shared types, constants and the init step table for the character LCD nibble sequencer.
// No dependencies; imported by every module of the block.
package lcdns_pkg;

	localparam int LINE_COLUMNS = 16;
	localparam int SPACE_STEPS  = 2 * LINE_COLUMNS;
	localparam int STEP_W       = $clog2(SPACE_STEPS + 4);
	localparam int WAIT_W       = 18;
	localparam int IDX_W        = 3;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 24;

	// request codes
	localparam logic [2:0] ACT_INIT  = 3'd0;
	localparam logic [2:0] ACT_CHAR  = 3'd1;
	localparam logic [2:0] ACT_CLEAR = 3'd2;
	localparam logic [2:0] ACT_MOVE  = 3'd3;
	localparam logic [2:0] ACT_LINE  = 3'd4;
	localparam logic [2:0] ACT_CGRAM = 3'd5;
	localparam logic [2:0] ACT_BLINK = 3'd6;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WAIT_CMD   = 3'd0;
	localparam logic [IDX_W-1:0] REG_WAIT_CHAR  = 3'd1;
	localparam logic [IDX_W-1:0] REG_WAIT_SLOW  = 3'd2;
	localparam logic [IDX_W-1:0] REG_WAIT_WAKE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_WAIT_POWER = 3'd4;

	// wait selectors
	localparam logic [2:0] WS_NONE  = 3'd0;
	localparam logic [2:0] WS_CMD   = 3'd1;
	localparam logic [2:0] WS_CHAR  = 3'd2;
	localparam logic [2:0] WS_SLOW  = 3'd3;
	localparam logic [2:0] WS_WAKE  = 3'd4;
	localparam logic [2:0] WS_POWER = 3'd5;

	// job kinds
	localparam logic [1:0] KIND_INIT = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_PAIR = 2'd2;
	localparam logic [1:0] KIND_LINE = 2'd3;

	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_DDRAM     = 8'h80;
	localparam logic [7:0] CMD_ROW1      = 8'h40;
	localparam logic [7:0] CMD_CGRAM     = 8'h40;
	localparam logic [7:0] CMD_BLINK_ON  = 8'h0f;
	localparam logic [7:0] CMD_BLINK_OFF = 8'h0c;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;

	localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(16);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] b0;
		logic       rs0;
		logic [2:0] ws0;
		logic [7:0] b1;
		logic       rs1;
		logic [2:0] ws1;
		logic       move_ok;
	} job_t;

	typedef struct packed {
		logic [3:0] nib;
		logic       strobe;
		logic [2:0] ws;
	} init_xfer_t;

	function automatic init_xfer_t init_xfer(input logic [STEP_W-1:0] step);
		init_xfer_t x;
		x = '{nib: 4'h0, strobe: 1'b1, ws: WS_NONE};
		case (step)
			STEP_W'(0):  x = '{nib: 4'h3, strobe: 1'b0, ws: WS_POWER};
			STEP_W'(1),
			STEP_W'(2),
			STEP_W'(3):  x = '{nib: 4'h3, strobe: 1'b1, ws: WS_WAKE};
			STEP_W'(4):  x = '{nib: 4'h2, strobe: 1'b1, ws: WS_WAKE};
			STEP_W'(5):  x = '{nib: 4'h2, strobe: 1'b1, ws: WS_NONE};
			STEP_W'(6):  x = '{nib: 4'h8, strobe: 1'b1, ws: WS_CMD};
			STEP_W'(7):  x = '{nib: 4'h0, strobe: 1'b1, ws: WS_NONE};
			STEP_W'(8):  x = '{nib: 4'h8, strobe: 1'b1, ws: WS_CMD};
			STEP_W'(9):  x = '{nib: 4'h0, strobe: 1'b1, ws: WS_NONE};
			STEP_W'(10): x = '{nib: 4'h1, strobe: 1'b1, ws: WS_SLOW};
			STEP_W'(11): x = '{nib: 4'h0, strobe: 1'b1, ws: WS_NONE};
			STEP_W'(12): x = '{nib: 4'h2, strobe: 1'b1, ws: WS_SLOW};
			STEP_W'(13): x = '{nib: 4'h0, strobe: 1'b1, ws: WS_NONE};
			STEP_W'(14): x = '{nib: 4'he, strobe: 1'b1, ws: WS_CMD};
			STEP_W'(15): x = '{nib: 4'h0, strobe: 1'b1, ws: WS_NONE};
			STEP_W'(16): x = '{nib: 4'h6, strobe: 1'b1, ws: WS_CMD};
			default:     x = '{nib: 4'h0, strobe: 1'b1, ws: WS_NONE};
		endcase
		return x;
	endfunction

endpackage

[src/char_lcd_nibble_sequencer_core.sv]
// Top level of the character LCD 4-bit bus sequencer.
// Instantiates lcdns_front, lcdns_queue and lcdns_back; depends on lcdns_pkg.
//
//   channel   | direction | payload
//   s_*       | in        | tuser: action; tdata: char_byte, row, column, cgram_address, blink_on
//   m_*       | out       | tdata: nibble, register_select, strobe_res, wait_cycles; tlast: last
//   wr_*      | in        | index 0..4 selects a wait register, write data 18 bits
//
// One transfer leaves per cycle while m_tready stays high: a request emits 2, 4, 17, 32 or
// 36 transfers (clear line: 2*LINE_COLUMNS+4), set by the single nibble sequencer in lcdns_back.
// Requests that emit nothing are dropped in the decoder; two jobs can wait in the queue.
// Reset is asynchronous and restores the wait registers to their defaults.
// A stalled output holds the sequencer; requests are taken until queue and decoder register fill.
module char_lcd_nibble_sequencer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [2:0]                        s_tuser,  // action
	input  logic [lcdns_pkg::IN_DATA_W-1:0]   s_tdata,  // char_byte, row, column, cgram_address, blink_on, pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lcdns_pkg::OUT_DATA_W-1:0]  m_tdata,  // nibble, register_select, strobe_res, wait_cycles
	output logic                              m_tlast,
	input  logic                              wr_en,
	input  logic [lcdns_pkg::IDX_W-1:0]       wr_index,
	input  logic [lcdns_pkg::WAIT_W-1:0]      wr_data
);
	import lcdns_pkg::*;

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	job_t fq_job, qb_job;

	lcdns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	lcdns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_job    (fq_job),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_job   (qb_job)
	);

	lcdns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

[src/lcdns_front.sv]
// Request decoder: accepts requests, drops those that emit nothing, registers a job descriptor.
// Depends on lcdns_pkg.
module lcdns_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [2:0]                       s_tuser,
	input  logic [lcdns_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                             job_valid,
	input  logic                             job_ready,
	output lcdns_pkg::job_t                  job
);
	import lcdns_pkg::*;

	logic       valid_s1;
	job_t       job_s1;
	job_t       dec;
	logic       keep;
	logic [7:0] ch;
	logic [1:0] row;
	logic [4:0] col;
	logic [5:0] addr;
	logic       blink;
	logic [7:0] row_bit;

	assign ch    = s_tdata[7:0];
	assign row   = s_tdata[9:8];
	assign col   = s_tdata[14:10];
	assign addr  = s_tdata[20:15];
	assign blink = s_tdata[21];
	assign row_bit = (row != 2'd0) ? CMD_ROW1 : 8'h00;

	always_comb begin
		dec  = '{kind: KIND_BYTE, b0: ch, rs0: 1'b0, ws0: WS_CMD,
			b1: CHAR_SPACE, rs1: 1'b1, ws1: WS_CHAR, move_ok: 1'b0};
		keep = 1'b1;
		case (s_tuser)
			ACT_INIT: dec.kind = KIND_INIT;
			ACT_CHAR: begin
				dec.rs0 = 1'b1;
				dec.ws0 = WS_CHAR;
			end
			ACT_CLEAR: begin
				dec.b0  = CMD_CLEAR;
				dec.ws0 = WS_SLOW;
			end
			ACT_MOVE: begin
				dec.b0 = CMD_DDRAM | row_bit | {3'b000, col};
				keep   = (row <= 2'd1) && (int'(col) < LINE_COLUMNS);
			end
			ACT_LINE: begin
				dec.kind    = KIND_LINE;
				dec.b0      = CMD_DDRAM | row_bit;
				dec.move_ok = (row <= 2'd1);
			end
			ACT_CGRAM: begin
				dec.kind = KIND_PAIR;
				dec.b0   = CMD_CGRAM | {2'b00, addr};
				dec.b1   = ch;
			end
			ACT_BLINK: dec.b0 = blink ? CMD_BLINK_ON : CMD_BLINK_OFF;
			default: keep = 1'b0;
		endcase
	end

	assign s_tready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= keep;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			job_s1 <= dec;
		end
	end

endmodule

[src/lcdns_queue.sv]
// Two-entry job queue between the decoder and the transfer sequencer.
// Depends on lcdns_pkg.
module lcdns_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lcdns_pkg::job_t in_job,
	output logic            out_valid,
	input  logic            out_ready,
	output lcdns_pkg::job_t out_job
);
	import lcdns_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_job   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

[src/lcdns_back.sv]
// Transfer sequencer: steps through a job one nibble a cycle, while the output is not stalled, into an output register.
// Holds the wait registers. Depends on lcdns_pkg.
module lcdns_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [lcdns_pkg::IDX_W-1:0]       wr_index,
	input  logic [lcdns_pkg::WAIT_W-1:0]      wr_data,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  lcdns_pkg::job_t                   job,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lcdns_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import lcdns_pkg::*;

	logic [WAIT_W-1:0] wait_cmd_q, wait_char_q, wait_slow_q, wait_wake_q, wait_power_q;
	logic              busy_q;
	job_t              job_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [3:0]        out_nib_q;
	logic              out_rs_q;
	logic              out_strobe_q;
	logic [WAIT_W-1:0] out_wait_q;
	logic              out_last_q;

	init_xfer_t        ix;
	logic [7:0]        cur_byte;
	logic              cur_rs;
	logic [2:0]        byte_ws;
	logic [3:0]        nib;
	logic              strobe;
	logic [2:0]        ws;
	logic [STEP_W-1:0] last_step;
	logic [WAIT_W-1:0] wait_val;
	logic              advance;
	logic              is_last;
	logic              in_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_cmd_q   <= WAIT_W'(622);
			wait_char_q  <= WAIT_W'(800);
			wait_slow_q  <= WAIT_W'(25552);
			wait_wake_q  <= WAIT_W'(2448);
			wait_power_q <= WAIT_W'(127760);
		end else if (wr_en) begin
			case (wr_index)
				REG_WAIT_CMD:   wait_cmd_q   <= wr_data;
				REG_WAIT_CHAR:  wait_char_q  <= wr_data;
				REG_WAIT_SLOW:  wait_slow_q  <= wr_data;
				REG_WAIT_WAKE:  wait_wake_q  <= wr_data;
				REG_WAIT_POWER: wait_power_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign in_move = (step_q < STEP_W'(2)) || (step_q >= STEP_W'(SPACE_STEPS + 2));

	always_comb begin
		ix       = init_xfer(step_q);
		cur_byte = job_q.b0;
		cur_rs   = job_q.rs0;
		byte_ws  = job_q.ws0;
		case (job_q.kind)
			KIND_BYTE: last_step = STEP_W'(1);
			KIND_PAIR: begin
				last_step = STEP_W'(3);
				if (step_q[1]) begin
					cur_byte = job_q.b1;
					cur_rs   = job_q.rs1;
					byte_ws  = job_q.ws1;
				end
			end
			KIND_LINE: begin
				last_step = job_q.move_ok ? STEP_W'(SPACE_STEPS + 3) : STEP_W'(SPACE_STEPS - 1);
				if (!(job_q.move_ok && in_move)) begin
					cur_byte = job_q.b1;
					cur_rs   = job_q.rs1;
					byte_ws  = job_q.ws1;
				end
			end
			default: last_step = INIT_LAST;
		endcase
		if (job_q.kind == KIND_INIT) begin
			nib    = ix.nib;
			strobe = ix.strobe;
			ws     = ix.ws;
			cur_rs = 1'b0;
		end else begin
			nib    = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
			strobe = 1'b1;
			ws     = step_q[0] ? byte_ws : WS_NONE;
		end
		case (ws)
			WS_CMD:   wait_val = wait_cmd_q;
			WS_CHAR:  wait_val = wait_char_q;
			WS_SLOW:  wait_val = wait_slow_q;
			WS_WAKE:  wait_val = wait_wake_q;
			WS_POWER: wait_val = wait_power_q;
			default:  wait_val = '0;
		endcase
	end

	assign advance   = busy_q && (!out_valid_q || m_tready);
	assign is_last   = (step_q == last_step);
	assign job_ready = !busy_q || (advance && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_valid && job_ready) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (advance && is_last) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				step_q <= step_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
		if (advance) begin
			out_nib_q    <= nib;
			out_rs_q     <= cur_rs;
			out_strobe_q <= strobe;
			out_wait_q   <= wait_val;
			out_last_q   <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_wait_q, out_strobe_q, out_rs_q, out_nib_q};
	assign m_tlast  = out_last_q;

endmodule

[src/lcdns_checker.sv]
// Port-level checks for char_lcd_nibble_sequencer_core, bound to the top level.
// Depends on lcdns_pkg.
module lcdns_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lcdns_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                              m_tlast
);
	import lcdns_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output transfer changed while stalled");

	a_unstrobed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[5] |-> m_tdata[3:0] == 4'h3 && !m_tdata[4] && !m_tlast)
		else $error("unstrobed transfer outside init power-on step");

	a_data_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[5])
		else $error("data register transfer without strobe");

endmodule

bind char_lcd_nibble_sequencer_core lcdns_checker u_lcdns_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[verif/char_lcd_nibble_sequencer_core_tb.sv]
// Self-checking testbench for char_lcd_nibble_sequencer_core: predicts the nibble transfer run
// of every accepted LCD request and checks each output transfer in order.
// Depends on lcdns_pkg and the RTL of the sequencer; needs nothing else.
module char_lcd_nibble_sequencer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lcdns_pkg::*;

	localparam logic [2:0] ACT_NONE = 3'd7;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [3:0] WAKE_NIBBLE = 4'h3;
	localparam logic [3:0] BUS4_NIBBLE = 4'h2;
	localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
	localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
	localparam logic [7:0] CMD_HOME       = 8'h02;
	localparam logic [7:0] CMD_DISP_ON    = 8'h0e;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

	localparam logic [WAIT_W-1:0] DEF_WAIT_CMD   = 18'd622;
	localparam logic [WAIT_W-1:0] DEF_WAIT_CHAR  = 18'd800;
	localparam logic [WAIT_W-1:0] DEF_WAIT_SLOW  = 18'd25552;
	localparam logic [WAIT_W-1:0] DEF_WAIT_WAKE  = 18'd2448;
	localparam logic [WAIT_W-1:0] DEF_WAIT_POWER = 18'd127760;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic       blink_on;
		logic [5:0] cgram_address;
		logic [4:0] column;
		logic [1:0] row;
		logic [7:0] char_byte;
	} lcd_req_fields_t;

	typedef struct {
		logic [2:0]      action;
		lcd_req_fields_t f;
	} lcd_req_t;

	typedef struct packed {
		logic [WAIT_W-1:0] wait_cycles;
		logic              strobe;
		logic              rs;
		logic [3:0]        nibble;
	} lcd_bus_word_t;

	typedef struct {
		lcd_bus_word_t word;
		logic          last;
	} lcd_xfer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [2:0] s_tuser = '0;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [WAIT_W-1:0] wr_data = '0;

	logic [WAIT_W-1:0] wait_cmd_q   = DEF_WAIT_CMD;
	logic [WAIT_W-1:0] wait_char_q  = DEF_WAIT_CHAR;
	logic [WAIT_W-1:0] wait_slow_q  = DEF_WAIT_SLOW;
	logic [WAIT_W-1:0] wait_wake_q  = DEF_WAIT_WAKE;
	logic [WAIT_W-1:0] wait_power_q = DEF_WAIT_POWER;

	lcd_xfer_t xfers_due[$];
	int errors = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	logic hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	char_lcd_nibble_sequencer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void due_xfer(logic [3:0] nib, logic rs, logic strobe,
			logic [WAIT_W-1:0] w);
		lcd_xfer_t x;
		x.word = '{wait_cycles: w, strobe: strobe, rs: rs, nibble: nib};
		x.last = 1'b0;
		xfers_due.push_back(x);
	endfunction

	// high nibble carries no wait, the low nibble carries the byte's wait
	function automatic void due_byte(logic [7:0] b, logic rs, logic [WAIT_W-1:0] w);
		due_xfer(b[7:4], rs, 1'b1, '0);
		due_xfer(b[3:0], rs, 1'b1, w);
	endfunction

	function automatic void due_move(logic [1:0] row, logic [4:0] col);
		logic [7:0] cmd;
		if (row > 2'd1 || col > 5'(LINE_COLUMNS - 1))
			return;
		cmd = CMD_DDRAM | {3'b000, col};
		if (row != 2'd0)
			cmd = cmd | CMD_ROW1;
		due_byte(cmd, RS_CMD, wait_cmd_q);
	endfunction

	function automatic void predict_request(lcd_req_t r);
		int first;
		lcd_xfer_t t;
		first = xfers_due.size();
		case (r.action)
			ACT_INIT: begin
				due_xfer(WAKE_NIBBLE, RS_CMD, 1'b0, wait_power_q);
				repeat (3) due_xfer(WAKE_NIBBLE, RS_CMD, 1'b1, wait_wake_q);
				due_xfer(BUS4_NIBBLE, RS_CMD, 1'b1, wait_wake_q);
				due_byte(CMD_FUNC_SET, RS_CMD, wait_cmd_q);
				due_byte(CMD_DISP_OFF, RS_CMD, wait_cmd_q);
				due_byte(CMD_CLEAR, RS_CMD, wait_slow_q);
				due_byte(CMD_HOME, RS_CMD, wait_slow_q);
				due_byte(CMD_DISP_ON, RS_CMD, wait_cmd_q);
				due_byte(CMD_ENTRY_MODE, RS_CMD, wait_cmd_q);
			end
			ACT_CHAR:  due_byte(r.f.char_byte, RS_DATA, wait_char_q);
			ACT_CLEAR: due_byte(CMD_CLEAR, RS_CMD, wait_slow_q);
			ACT_MOVE:  due_move(r.f.row, r.f.column);
			ACT_LINE: begin
				due_move(r.f.row, '0);
				repeat (LINE_COLUMNS) due_byte(CHAR_SPACE, RS_DATA, wait_char_q);
				due_move(r.f.row, '0);
			end
			ACT_CGRAM: begin
				due_byte(CMD_CGRAM | {2'b00, r.f.cgram_address}, RS_CMD, wait_cmd_q);
				due_byte(r.f.char_byte, RS_DATA, wait_char_q);
			end
			ACT_BLINK:
				due_byte(r.f.blink_on ? CMD_BLINK_ON : CMD_BLINK_OFF, RS_CMD, wait_cmd_q);
			default: ;
		endcase
		if (xfers_due.size() > first) begin
			t = xfers_due.pop_back();
			t.last = 1'b1;
			xfers_due.push_back(t);
		end
	endfunction

	function automatic lcd_req_t req(logic [2:0] action, logic [7:0] ch, logic [1:0] row,
			logic [4:0] col, logic [5:0] addr, logic blink);
		lcd_req_t r;
		r.action = action;
		r.f = '{blink_on: blink, cgram_address: addr, column: col, row: row, char_byte: ch};
		return r;
	endfunction

	// mostly well-formed requests with random content, a little noise
	function automatic lcd_req_t random_request();
		lcd_req_t r;
		int pick;
		r.f = $bits(lcd_req_fields_t)'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 3)       r.action = ACT_INIT;
		else if (pick < 28) r.action = ACT_CHAR;
		else if (pick < 36) r.action = ACT_CLEAR;
		else if (pick < 56) r.action = ACT_MOVE;
		else if (pick < 63) r.action = ACT_LINE;
		else if (pick < 78) r.action = ACT_CGRAM;
		else if (pick < 96) r.action = ACT_BLINK;
		else                r.action = ACT_NONE;
		if (r.action == ACT_MOVE && $urandom_range(0, 3) != 0) begin
			r.f.row = 2'($urandom_range(0, 1));
			r.f.column = 5'($urandom_range(0, LINE_COLUMNS - 1));
		end
		return r;
	endfunction

	function automatic logic [WAIT_W-1:0] random_wait();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return WAIT_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [WAIT_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_WAIT_CMD:   wait_cmd_q = val;
			REG_WAIT_CHAR:  wait_char_q = val;
			REG_WAIT_SLOW:  wait_slow_q = val;
			REG_WAIT_WAKE:  wait_wake_q = val;
			REG_WAIT_POWER: wait_power_q = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// indexes past the last register must leave every wait untouched
	task automatic write_spare_regs();
		for (int i = int'(REG_WAIT_POWER) + 1; i < 2 ** IDX_W; i++)
			write_reg(IDX_W'(i), WAIT_W'($urandom));
	endtask

	task automatic send_request(lcd_req_t r);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.action;
		s_tdata <= IN_DATA_W'(r.f);
		do @(posedge clk); while (!s_tready);
		predict_request(r);
	endtask

	task automatic wait_for_lcd_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (xfers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_each_request();
		src_idle_pct = 10;
		snk_idle_pct = 10;
		send_request(req(ACT_INIT, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_CHAR, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_CHAR, 8'hff, 2'd3, 5'd31, 6'd63, 1'b1));
		send_request(req(ACT_CLEAR, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_MOVE, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_MOVE, 8'h00, 2'd1, 5'd15, 6'd0, 1'b0));
		send_request(req(ACT_MOVE, 8'h00, 2'd2, 5'd3, 6'd0, 1'b0));
		send_request(req(ACT_MOVE, 8'h00, 2'd0, 5'd16, 6'd0, 1'b0));
		send_request(req(ACT_MOVE, 8'hff, 2'd3, 5'd31, 6'd63, 1'b1));
		send_request(req(ACT_LINE, 8'h00, 2'd0, 5'd9, 6'd0, 1'b0));
		send_request(req(ACT_LINE, 8'h00, 2'd1, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_LINE, 8'h00, 2'd2, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_LINE, 8'h00, 2'd3, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_CGRAM, 8'ha5, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_CGRAM, 8'h5a, 2'd0, 5'd0, 6'd63, 1'b0));
		send_request(req(ACT_BLINK, 8'h00, 2'd0, 5'd0, 6'd0, 1'b1));
		send_request(req(ACT_BLINK, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_NONE, 8'hff, 2'd1, 5'd5, 6'd63, 1'b1));
		wait_for_lcd_idle();
	endtask

	task automatic test_wait_registers();
		write_reg(REG_WAIT_CMD, '0);
		write_reg(REG_WAIT_CHAR, '0);
		write_reg(REG_WAIT_SLOW, '0);
		write_reg(REG_WAIT_WAKE, '0);
		write_reg(REG_WAIT_POWER, '0);
		write_spare_regs();
		send_request(req(ACT_INIT, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_CGRAM, 8'h3c, 2'd0, 5'd0, 6'd21, 1'b0));
		send_request(req(ACT_LINE, 8'h00, 2'd1, 5'd0, 6'd0, 1'b0));
		wait_for_lcd_idle();
		write_reg(REG_WAIT_CMD, '1);
		write_reg(REG_WAIT_CHAR, '1);
		write_reg(REG_WAIT_SLOW, '1);
		write_reg(REG_WAIT_WAKE, '1);
		write_reg(REG_WAIT_POWER, '1);
		write_spare_regs();
		send_request(req(ACT_INIT, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_CHAR, 8'h41, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_CLEAR, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_MOVE, 8'h00, 2'd1, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_BLINK, 8'h00, 2'd0, 5'd0, 6'd0, 1'b1));
		wait_for_lcd_idle();
	endtask

	task automatic test_random_traffic(int n, int src_pct, int snk_pct);
		write_reg(REG_WAIT_CMD, random_wait());
		write_reg(REG_WAIT_CHAR, random_wait());
		write_reg(REG_WAIT_SLOW, random_wait());
		write_reg(REG_WAIT_WAKE, random_wait());
		write_reg(REG_WAIT_POWER, random_wait());
		if ($urandom_range(0, 1) != 0)
			write_spare_regs();
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (n) send_request(random_request());
		wait_for_lcd_idle();
	endtask

	// output held off long enough for the request queue to fill and stall the input
	task automatic test_output_stall();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_request <= 1'b1;
		send_request(req(ACT_LINE, 8'h00, 2'd1, 5'd0, 6'd0, 1'b0));
		send_request(req(ACT_INIT, 8'h00, 2'd0, 5'd0, 6'd0, 1'b0));
		repeat (10) send_request(random_request());
		wait_for_lcd_idle();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		lcd_bus_word_t got;
		lcd_xfer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = lcd_bus_word_t'(m_tdata);
			if (xfers_due.size() == 0) begin
				$error("unexpected transfer: nibble %h rs %b strobe %b wait %0d last %b",
					got.nibble, got.rs, got.strobe, got.wait_cycles, m_tlast);
				errors++;
			end else begin
				want = xfers_due.pop_front();
				if (got.nibble !== want.word.nibble) begin
					$error("nibble: expected %h, got %h", want.word.nibble, got.nibble);
					errors++;
				end
				if (got.rs !== want.word.rs) begin
					$error("register_select: expected %b, got %b", want.word.rs, got.rs);
					errors++;
				end
				if (got.strobe !== want.word.strobe) begin
					$error("strobe_res: expected %b, got %b", want.word.strobe, got.strobe);
					errors++;
				end
				if (got.wait_cycles !== want.word.wait_cycles) begin
					$error("wait_cycles: expected %0d, got %0d", want.word.wait_cycles,
						got.wait_cycles);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_request();
		test_wait_registers();
		test_random_traffic(100, 26, 70);
		test_random_traffic(100, 70, 26);
		test_random_traffic(100, 0, 0);
		test_output_stall();
		wait_for_lcd_idle();
		if (errors == 0 && xfers_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
